/* rtl/modexp_pkg.sv */
package modexp_pkg;

    // Widths fixed by the stream and configuration fields
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER   = 2'd1;

    // Reset values of the configuration registers
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 16'd2;
    localparam logic [FIELD_W-1:0] POWER_RESET   = 16'd1;

    // Smallest modulus used; anything below is taken as this
    localparam int MIN_MODULUS = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_KICK,
        ST_RED_WAIT,
        ST_BIT_SEL,
        ST_MUL_WAIT,
        ST_SQR_KICK,
        ST_SQR_WAIT,
        ST_HOLD
    } state_t;

endpackage

/* rtl/modexp_mulmod.sv */
// Interleaved modular multiplier: multiplier operand scanned MSB first,
// one bit per cycle. Operand a and the running sum stay below m.
module modexp_mulmod #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] modulus,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W+1:0]  sum;
    logic [W+1:0]  red1;
    logic [W+1:0]  red2;
    logic [W+1:0]  mod_ext;

    always_comb begin
        mod_ext = {2'b00, modulus};
        // 2*acc + a < 3m, so two conditional subtractions suffice
        sum  = {1'b0, acc_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        red1 = (sum >= mod_ext) ? sum - mod_ext : sum;
        red2 = (red1 >= mod_ext) ? red1 - mod_ext : red1;
        acc_next = red2[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* rtl/modexp_ctrl.sv */
// Square-and-multiply sequencer, exponent scanned LSB first.
module modexp_ctrl #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_base,
    input  logic [W-1:0] in_power,
    output logic         mul_start,
    output logic [W-1:0] mul_a,
    output logic [W-1:0] mul_b,
    input  logic         mul_done,
    input  logic [W-1:0] mul_res,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [W-1:0] res_value
);

    localparam int CW = $clog2(W + 1);

    modexp_pkg::state_t state_reg, state_next;

    logic [W-1:0]  base_reg;
    logic [W-1:0]  exp_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  sq_reg;
    logic [CW-1:0] bit_cnt_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (in_valid) state_next = modexp_pkg::ST_RED_KICK;
            end
            modexp_pkg::ST_RED_KICK: state_next = modexp_pkg::ST_RED_WAIT;
            modexp_pkg::ST_RED_WAIT: begin
                if (mul_done) state_next = modexp_pkg::ST_BIT_SEL;
            end
            modexp_pkg::ST_BIT_SEL: begin
                state_next = exp_reg[0] ? modexp_pkg::ST_MUL_WAIT : modexp_pkg::ST_SQR_WAIT;
            end
            modexp_pkg::ST_MUL_WAIT: begin
                if (mul_done) state_next = modexp_pkg::ST_SQR_KICK;
            end
            modexp_pkg::ST_SQR_KICK: state_next = modexp_pkg::ST_SQR_WAIT;
            modexp_pkg::ST_SQR_WAIT: begin
                if (mul_done) begin
                    state_next = (bit_cnt_reg == CW'(1)) ? modexp_pkg::ST_HOLD
                                                         : modexp_pkg::ST_BIT_SEL;
                end
            end
            modexp_pkg::ST_HOLD: begin
                if (res_ready) state_next = modexp_pkg::ST_IDLE;
            end
            default: state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = sq_reg;
        mul_b     = sq_reg;
        res_valid = 1'b0;
        case (state_reg)
            modexp_pkg::ST_IDLE: in_ready = 1'b1;
            modexp_pkg::ST_RED_KICK: begin
                // base * 1 mod m reduces the base
                mul_start = 1'b1;
                mul_a     = W'(1);
                mul_b     = base_reg;
            end
            modexp_pkg::ST_BIT_SEL: begin
                mul_start = 1'b1;
                mul_a     = exp_reg[0] ? acc_reg : sq_reg;
            end
            modexp_pkg::ST_SQR_KICK: mul_start = 1'b1;
            modexp_pkg::ST_HOLD:     res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= modexp_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == modexp_pkg::ST_IDLE && in_valid) begin
                bit_cnt_reg <= CW'(W);
            end else if (state_reg == modexp_pkg::ST_SQR_WAIT && mul_done) begin
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (in_valid) begin
                    base_reg <= in_base;
                    exp_reg  <= in_power;
                end
            end
            modexp_pkg::ST_RED_WAIT: begin
                if (mul_done) begin
                    sq_reg  <= mul_res;
                    acc_reg <= W'(1);
                end
            end
            modexp_pkg::ST_MUL_WAIT: begin
                if (mul_done) acc_reg <= mul_res;
            end
            modexp_pkg::ST_SQR_WAIT: begin
                if (mul_done) begin
                    sq_reg  <= mul_res;
                    exp_reg <= {1'b0, exp_reg[W-1:1]};
                end
            end
            default: ;
        endcase
    end

    assign res_value = acc_reg;

endmodule

/* rtl/modular_exponentiation.sv */
// One bit-serial modular multiplier does all the products: two per exponent bit
// when the bit is set, one otherwise, plus one product to reduce the base.
// Flow: one item at a time; the next is taken once the result is in the output
// register.
// Reset: aresetn synchronous, active low; modulus returns to 2, power to 1.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [modexp_pkg::FIELD_W-1:0]      s_tdata,   // [15:0] base_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [modexp_pkg::FIELD_W-1:0]      m_tdata,   // [15:0] power_result
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [modexp_pkg::FIELD_W-1:0]      cfg_data
);

    localparam int W = OPERAND_WIDTH;

    logic [modexp_pkg::FIELD_W-1:0] modulus_reg;
    logic [modexp_pkg::FIELD_W-1:0] power_reg;
    logic                           out_valid_reg;
    logic [modexp_pkg::FIELD_W-1:0] out_data_reg;

    logic [31:0]  mod_ext, pow_ext, base_ext, res_ext;
    logic [W-1:0] mod_w, mod_eff, pow_w, base_w;

    logic         mul_start, mul_done;
    logic [W-1:0] mul_a, mul_b, mul_res;
    logic         res_valid, res_ready;
    logic [W-1:0] res_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= modexp_pkg::MODULUS_RESET;
            power_reg   <= modexp_pkg::POWER_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                modexp_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                modexp_pkg::REG_POWER:   power_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        mod_ext  = {{(32 - modexp_pkg::FIELD_W){1'b0}}, modulus_reg};
        pow_ext  = {{(32 - modexp_pkg::FIELD_W){1'b0}}, power_reg};
        base_ext = {{(32 - modexp_pkg::FIELD_W){1'b0}}, s_tdata};
        mod_w    = mod_ext[W-1:0];
        pow_w    = pow_ext[W-1:0];
        base_w   = base_ext[W-1:0];
        mod_eff  = (mod_w < W'(modexp_pkg::MIN_MODULUS)) ? W'(modexp_pkg::MIN_MODULUS) : mod_w;
        res_ext  = 32'(res_value);
    end

    modexp_ctrl #(.W(W)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_base   (base_w),
        .in_power  (pow_w),
        .mul_start (mul_start),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_done  (mul_done),
        .mul_res   (mul_res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_value (res_value)
    );

    modexp_mulmod #(.W(W)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_eff),
        .done    (mul_done),
        .result  (mul_res)
    );

    // Output register frees the sequencer while the result waits
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) out_data_reg <= res_ext[modexp_pkg::FIELD_W-1:0];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/modexp_checker.sv */
module modexp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Held result stays put until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in flight: no input transfer right after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Residue is always below the largest modulus
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'hFFFF)
        else $error("result out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
